@@ rtl/hcmc_pkg.sv @@
// Package for the heat/cool mode controller: event and mode codes, field widths,
// register indexes and the controller state record. No dependencies.
`default_nettype none

package hcmc_pkg;

	localparam int unsigned LEVEL_W = 5;
	localparam int unsigned HYST_W  = 3;
	localparam int unsigned DUTY_W  = 7;
	localparam int unsigned TEMP_W  = 10;
	localparam int unsigned ROOM_W  = 13;
	localparam int unsigned KIND_W  = 3;
	localparam int unsigned CFG_W   = 10;
	localparam int unsigned IDX_W   = 2;

	localparam logic [KIND_W-1:0] KIND_TICK   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_MODE   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_DOWN   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_UP     = 3'd3;
	localparam logic [KIND_W-1:0] KIND_OFF    = 3'd4;
	localparam logic [KIND_W-1:0] KIND_SAMPLE = 3'd5;

	localparam logic [1:0] MODE_OFF  = 2'd0;
	localparam logic [1:0] MODE_HEAT = 2'd1;
	localparam logic [1:0] MODE_COOL = 2'd2;
	localparam logic [1:0] MODE_AUTO = 2'd3;

	localparam logic [IDX_W-1:0] REG_SUMMER   = 2'd0;
	localparam logic [IDX_W-1:0] REG_WINTER   = 2'd1;
	localparam logic [IDX_W-1:0] REG_COOL_MIN = 2'd2;
	localparam logic [IDX_W-1:0] REG_BOOST    = 2'd3;

	localparam logic [TEMP_W-1:0] SUMMER_RST   = 10'd600;
	localparam logic [TEMP_W-1:0] WINTER_RST   = 10'd400;
	localparam logic [DUTY_W-1:0] COOL_MIN_RST = 7'd25;
	localparam logic [TEMP_W-1:0] BOOST_RST    = 10'd520;

	localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd100;

	typedef struct packed {
		logic [1:0]         mode;
		logic               heat_flag;
		logic               cool_flag;
		logic [LEVEL_W-1:0] heat_level;
		logic [LEVEL_W-1:0] cool_level;
		logic [HYST_W-1:0]  hyst;
		logic [LEVEL_W-1:0] phase;
		logic               timer_on;
		logic               pin;
		logic [DUTY_W-1:0]  duty;
	} hcmc_state_t;

endpackage

`default_nettype wire

@@ rtl/heat_cool_mode_controller.sv @@
// Heat/cool mode controller: one result word for every accepted input word, one word per
// cycle when not stalled. The state update and the result register sit behind a single pass
// of logic; the result register holds a word while the output stalls. Depends on hcmc_pkg.
`default_nettype none

module heat_cool_mode_controller
	import hcmc_pkg::*;
#(
	parameter int unsigned PWM_STEPS = 20,
	parameter int unsigned HYST_MAX  = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_wdata,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	// setpoint_tenths[9:0], outside_tenths[19:10], room_tenths[32:20]
	input  wire logic [39:0]       s_tdata,
	// kind[2:0]
	input  wire logic [KIND_W-1:0] s_tuser,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	// heater_pin[0], cooler_duty[7:1], heater_flag[8], cooler_flag[9], mode_now[11:10],
	// heater_level[16:12], cooler_level[21:17], hysteresis[24:22], pwm_running[25]
	output logic [31:0]            m_tdata
);

	localparam logic [LEVEL_W-1:0] STEPS = LEVEL_W'(PWM_STEPS);
	localparam logic [LEVEL_W-1:0] HALF  = LEVEL_W'(PWM_STEPS / 2);
	localparam logic [HYST_W-1:0]  HMAX  = HYST_W'(HYST_MAX);

	logic [TEMP_W-1:0] summer_q, winter_q, boost_q;
	logic [DUTY_W-1:0] cool_min_q;
	hcmc_state_t       st_q, st_nxt;
	logic              m_tvalid_q;
	logic [31:0]       m_tdata_q;

	logic [DUTY_W-1:0] duty_lut [2**LEVEL_W];

	for (genvar g = 0; g < 2**LEVEL_W; g++) begin : g_lut
		assign duty_lut[g] = DUTY_W'((g * 100) / PWM_STEPS);
	end

	logic [TEMP_W-1:0]   sp, ot;
	logic [ROOM_W-1:0]   rt;
	logic signed [14:0]  sp_s, rt_s, band_s, cool_err, heat_err, d;
	logic [17:0]         quot_prod;
	logic [7:0]          lvl5;
	logic [LEVEL_W-1:0]  heat_lvl;
	logic [LEVEL_W-1:0]  lvl_up, lvl_dn;
	logic                accept;

	assign sp = s_tdata[9:0];
	assign ot = s_tdata[19:10];
	assign rt = s_tdata[32:20];

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		sp_s     = $signed({5'b0, sp});
		rt_s     = $signed({2'b0, rt});
		band_s   = $signed(15'({4'b0, st_q.hyst} * 7'd10));
		cool_err = rt_s - sp_s;
		heat_err = sp_s - rt_s;
		// floor(x/5) as x*205 >> 10, exact for x below 1024
		quot_prod = {8'b0, heat_err[9:0]} * 18'd205;
		lvl5      = quot_prod[17:10];
		if (lvl5 > 8'(PWM_STEPS))
			heat_lvl = STEPS;
		else if (lvl5 < 8'(PWM_STEPS / 2))
			heat_lvl = HALF;
		else if (sp > boost_q)
			heat_lvl = STEPS;
		else
			heat_lvl = lvl5[LEVEL_W-1:0];
		d = cool_err;
		if (d < $signed({8'b0, cool_min_q}))
			d = $signed({8'b0, cool_min_q});
		if (d > $signed({8'b0, DUTY_FULL}))
			d = $signed({8'b0, DUTY_FULL});
		lvl_up = st_q.cool_level + LEVEL_W'(1);
		lvl_dn = st_q.cool_level - LEVEL_W'(1);
	end

	always_comb begin
		st_nxt = st_q;
		case (s_tuser)
			KIND_TICK: begin
				if (st_q.timer_on) begin
					st_nxt.pin = st_q.phase < st_q.heat_level;
					if (st_q.phase >= STEPS) begin
						if (st_q.heat_level != '0)
							st_nxt.pin = 1'b1;
						st_nxt.phase = LEVEL_W'(1);
					end else begin
						st_nxt.phase = st_q.phase + LEVEL_W'(1);
					end
				end
			end
			KIND_MODE: begin
				case (st_q.mode)
					MODE_OFF, MODE_AUTO: begin
						st_nxt.mode       = MODE_HEAT;
						st_nxt.cool_flag  = 1'b0;
						st_nxt.duty       = '0;
						st_nxt.heat_flag  = 1'b1;
						st_nxt.heat_level = '0;
						st_nxt.phase      = '0;
						st_nxt.timer_on   = 1'b1;
					end
					MODE_HEAT: begin
						st_nxt.mode       = MODE_COOL;
						st_nxt.cool_flag  = 1'b1;
						st_nxt.heat_flag  = 1'b0;
						st_nxt.timer_on   = 1'b0;
						st_nxt.pin        = 1'b0;
						st_nxt.cool_level = '0;
					end
					default: begin
						st_nxt.mode       = MODE_AUTO;
						st_nxt.hyst       = '0;
						st_nxt.heat_flag  = 1'b0;
						st_nxt.heat_level = '0;
						st_nxt.phase      = '0;
						st_nxt.timer_on   = 1'b0;
						st_nxt.pin        = 1'b0;
						st_nxt.cool_flag  = 1'b0;
						st_nxt.duty       = '0;
					end
				endcase
			end
			KIND_DOWN, KIND_UP: begin
				case (st_q.mode)
					MODE_HEAT: begin
						if (s_tuser == KIND_UP && st_q.heat_level < STEPS)
							st_nxt.heat_level = st_q.heat_level + LEVEL_W'(1);
						else if (s_tuser == KIND_DOWN && st_q.heat_level != '0)
							st_nxt.heat_level = st_q.heat_level - LEVEL_W'(1);
					end
					MODE_COOL: begin
						if (s_tuser == KIND_UP && st_q.cool_level < STEPS) begin
							st_nxt.cool_level = lvl_up;
							st_nxt.duty       = duty_lut[lvl_up];
						end else if (s_tuser == KIND_DOWN && st_q.cool_level != '0) begin
							st_nxt.cool_level = lvl_dn;
							st_nxt.duty       = duty_lut[lvl_dn];
						end
					end
					MODE_AUTO: begin
						if (s_tuser == KIND_UP && st_q.hyst < HMAX)
							st_nxt.hyst = st_q.hyst + HYST_W'(1);
						else if (s_tuser == KIND_DOWN && st_q.hyst != '0)
							st_nxt.hyst = st_q.hyst - HYST_W'(1);
					end
					default: ;
				endcase
			end
			KIND_OFF: begin
				st_nxt.mode      = MODE_OFF;
				st_nxt.cool_flag = 1'b0;
				st_nxt.heat_flag = 1'b0;
				st_nxt.timer_on  = 1'b0;
				st_nxt.pin       = 1'b0;
				st_nxt.duty      = '0;
				st_nxt.hyst      = '0;
			end
			KIND_SAMPLE: begin
				if (st_q.mode == MODE_AUTO) begin
					if (ot > summer_q) begin
						if (cool_err > 15'sd0) begin
							st_nxt.heat_flag  = 1'b0;
							st_nxt.heat_level = '0;
							st_nxt.phase      = '0;
							st_nxt.timer_on   = 1'b0;
							st_nxt.pin        = 1'b0;
							st_nxt.cool_flag  = 1'b1;
							st_nxt.duty       = d[DUTY_W-1:0];
						end else if (rt_s < sp_s - band_s) begin
							st_nxt.duty       = '0;
							st_nxt.cool_flag  = 1'b0;
							st_nxt.heat_flag  = 1'b1;
							st_nxt.heat_level = HALF;
							st_nxt.phase      = '0;
							st_nxt.timer_on   = 1'b1;
						end
					end else if (ot < winter_q) begin
						st_nxt.cool_flag = 1'b0;
						st_nxt.duty      = '0;
						if (heat_err > 15'sd0) begin
							st_nxt.heat_flag  = 1'b1;
							st_nxt.heat_level = heat_lvl;
							st_nxt.phase      = '0;
							st_nxt.timer_on   = 1'b1;
						end else if (rt_s > sp_s + band_s) begin
							st_nxt.heat_level = '0;
							st_nxt.heat_flag  = 1'b0;
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			summer_q   <= SUMMER_RST;
			winter_q   <= WINTER_RST;
			cool_min_q <= COOL_MIN_RST;
			boost_q    <= BOOST_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SUMMER:   summer_q   <= cfg_wdata;
				REG_WINTER:   winter_q   <= cfg_wdata;
				REG_COOL_MIN: cool_min_q <= cfg_wdata[DUTY_W-1:0];
				REG_BOOST:    boost_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept)
				st_q <= st_nxt;
			if (s_tready)
				m_tvalid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			m_tdata_q <= {6'b0, st_nxt.timer_on, st_nxt.hyst, st_nxt.cool_level,
				st_nxt.heat_level, st_nxt.mode, st_nxt.cool_flag, st_nxt.heat_flag,
				st_nxt.duty, st_nxt.pin};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_hyst_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.hyst <= HMAX)
		else $error("hysteresis above limit");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.heat_level <= STEPS && st_q.cool_level <= STEPS && st_q.phase <= STEPS)
		else $error("level or phase above PWM steps");

	a_timer_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.mode == MODE_COOL || st_q.mode == MODE_OFF) |-> !st_q.timer_on)
		else $error("heater timer running in off or cool mode");

	a_out_mode: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> m_tdata_q[11:10] == st_q.mode && m_tdata_q[25] == st_q.timer_on)
		else $error("result word out of step with state");

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// Self-checking bench for heat_cool_mode_controller: random and directed event words
// are checked against a cycle-free model of the mode, PWM and auto logic.
// Depends on hcmc_pkg and the controller RTL.
`timescale 1ns / 1ps

module tb
	import hcmc_pkg::*;
();

	localparam int PWM_STEPS = 20;
	localparam int HYST_MAX  = 4;
	localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
	localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [TEMP_W-1:0] sp;
		logic [TEMP_W-1:0] ot;
		logic [ROOM_W-1:0] rt;
	} ctl_event_t;

	// same bit order as m_tdata[25:0]
	typedef struct packed {
		logic               running;
		logic [HYST_W-1:0]  hyst;
		logic [LEVEL_W-1:0] cool_level;
		logic [LEVEL_W-1:0] heat_level;
		logic [1:0]         mode;
		logic               cool_flag;
		logic               heat_flag;
		logic [DUTY_W-1:0]  duty;
		logic               pin;
	} status_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cfg_we    = 1'b0;
	logic [IDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]  cfg_wdata = '0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [39:0]       s_tdata   = '0;
	logic [KIND_W-1:0] s_tuser   = '0;
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [31:0]       m_tdata;

	ctl_event_t  event_q[$];
	status_t     status_q[$];
	hcmc_state_t ctl = '0;
	int          summer_thr = int'(SUMMER_RST);
	int          winter_thr = int'(WINTER_RST);
	int          cool_min   = int'(COOL_MIN_RST);
	int          boost_sp   = int'(BOOST_RST);

	logic [1:0]  gen_mode2 = MODE_OFF;
	logic        steady    = 1'b0;
	logic        long_hold = 1'b0;
	logic        hold_done = 1'b0;
	logic        s_took    = 1'b0;
	ctl_event_t  bus_ev;
	int          send_gap  = 0;
	int          stall_left = 0;
	int          hold_left = 0;
	int          fail_count = 0;
	int          words_in = 0;
	int          words_out = 0;
	int          auto_samples = 0;
	int          running_ticks = 0;
	int          settings_used = 0;

	heat_cool_mode_controller #(
		.PWM_STEPS(PWM_STEPS),
		.HYST_MAX (HYST_MAX)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// ---- controller model ----
	function automatic void heater_stop();
		ctl.heat_flag  = 1'b0;
		ctl.heat_level = '0;
		ctl.phase      = '0;
		ctl.timer_on   = 1'b0;
		ctl.pin        = 1'b0;
	endfunction

	function automatic void heater_start(input int lvl);
		ctl.cool_flag  = 1'b0;
		ctl.heat_flag  = 1'b1;
		ctl.heat_level = LEVEL_W'(lvl);
		ctl.phase      = '0;
		ctl.timer_on   = 1'b1;
	endfunction

	function automatic void advance_controller(input logic [KIND_W-1:0] kind,
			input int sp, input int ot, input int rt);
		int band, err, lvl;
		band = int'(ctl.hyst) * 10;
		case (kind)
			KIND_TICK: begin
				if (ctl.timer_on) begin
					ctl.pin = (ctl.phase >= ctl.heat_level) ? 1'b0 : 1'b1;
					if (ctl.phase >= PWM_STEPS) begin
						if (ctl.heat_level != 0) ctl.pin = 1'b1;
						ctl.phase = '0;
					end
					ctl.phase = ctl.phase + 1'b1;
				end
			end
			KIND_MODE: begin
				ctl.mode = (ctl.mode == MODE_AUTO) ? MODE_HEAT : ctl.mode + 1'b1;
				if (ctl.mode == MODE_HEAT) begin
					ctl.cool_flag = 1'b0;
					ctl.duty      = '0;
					heater_start(0);
				end else if (ctl.mode == MODE_COOL) begin
					ctl.cool_flag  = 1'b1;
					ctl.heat_flag  = 1'b0;
					ctl.timer_on   = 1'b0;
					ctl.pin        = 1'b0;
					ctl.cool_level = '0;
				end else begin
					ctl.hyst = '0;
					heater_stop();
					ctl.cool_flag = 1'b0;
					ctl.duty      = '0;
				end
			end
			KIND_DOWN, KIND_UP: begin
				if (ctl.mode == MODE_HEAT) begin
					if (kind == KIND_UP && ctl.heat_level < PWM_STEPS)
						ctl.heat_level = ctl.heat_level + 1'b1;
					else if (kind == KIND_DOWN && ctl.heat_level > 0)
						ctl.heat_level = ctl.heat_level - 1'b1;
				end else if (ctl.mode == MODE_COOL) begin
					lvl = int'(ctl.cool_level);
					if (kind == KIND_UP && lvl < PWM_STEPS) lvl++;
					else if (kind == KIND_DOWN && lvl > 0) lvl--;
					if (lvl != ctl.cool_level) begin
						ctl.cool_level = LEVEL_W'(lvl);
						ctl.duty       = DUTY_W'(lvl * 100 / PWM_STEPS);
					end
				end else if (ctl.mode == MODE_AUTO) begin
					if (kind == KIND_UP && ctl.hyst < HYST_MAX)
						ctl.hyst = ctl.hyst + 1'b1;
					else if (kind == KIND_DOWN && ctl.hyst > 0)
						ctl.hyst = ctl.hyst - 1'b1;
				end
			end
			KIND_OFF: begin
				ctl.mode      = MODE_OFF;
				ctl.cool_flag = 1'b0;
				ctl.heat_flag = 1'b0;
				ctl.timer_on  = 1'b0;
				ctl.pin       = 1'b0;
				ctl.duty      = '0;
				ctl.hyst      = '0;
			end
			KIND_SAMPLE: begin
				if (ctl.mode == MODE_AUTO) begin
					if (ot > summer_thr) begin
						err = rt - sp;
						if (err > 0) begin
							heater_stop();
							ctl.cool_flag = 1'b1;
							if (err < cool_min) err = cool_min;
							if (err > 100) err = 100;
							ctl.duty = DUTY_W'(err);
						end else if (rt < sp - band) begin
							ctl.duty = '0;
							heater_start(PWM_STEPS / 2);
						end
					end else if (ot < winter_thr) begin
						err = sp - rt;
						ctl.cool_flag = 1'b0;
						ctl.duty      = '0;
						if (err > 0) begin
							lvl = err / 5;
							if (lvl > PWM_STEPS) lvl = PWM_STEPS;
							else if (lvl < PWM_STEPS / 2) lvl = PWM_STEPS / 2;
							else if (sp > boost_sp) lvl = PWM_STEPS;
							heater_start(lvl);
						end else if (rt > sp + band) begin
							ctl.heat_level = '0;
							ctl.heat_flag  = 1'b0;
						end
					end
				end
			end
			default: ;
		endcase
	endfunction

	function automatic status_t controller_status();
		status_t s;
		s.running    = ctl.timer_on;
		s.hyst       = ctl.hyst;
		s.cool_level = ctl.cool_level;
		s.heat_level = ctl.heat_level;
		s.mode       = ctl.mode;
		s.cool_flag  = ctl.cool_flag;
		s.heat_flag  = ctl.heat_flag;
		s.duty       = ctl.duty;
		s.pin        = ctl.pin;
		return s;
	endfunction

	function automatic string status_text(input status_t s);
		return $sformatf({"pin=%0d duty=%0d hflag=%0d cflag=%0d mode=%0d",
			" hlvl=%0d clvl=%0d hyst=%0d run=%0d"},
			s.pin, s.duty, s.heat_flag, s.cool_flag, s.mode, s.heat_level, s.cool_level,
			s.hyst, s.running);
	endfunction

	function automatic void check_status(input status_t want, input status_t got);
		string bad;
		bad = "";
		if (got.pin != want.pin)               bad = {bad, " heater_pin"};
		if (got.duty != want.duty)             bad = {bad, " cooler_duty"};
		if (got.heat_flag != want.heat_flag)   bad = {bad, " heater_flag"};
		if (got.cool_flag != want.cool_flag)   bad = {bad, " cooler_flag"};
		if (got.mode != want.mode)             bad = {bad, " mode_now"};
		if (got.heat_level != want.heat_level) bad = {bad, " heater_level"};
		if (got.cool_level != want.cool_level) bad = {bad, " cooler_level"};
		if (got.hyst != want.hyst)             bad = {bad, " hysteresis"};
		if (got.running != want.running)       bad = {bad, " pwm_running"};
		if (bad != "") begin
			fail_count++;
			if (fail_count <= 10) begin
				$display("%0t result %0d mismatch:%s", $time, words_out, bad);
				$display("  expected %s", status_text(want));
				$display("  actual   %s", status_text(got));
			end
		end
	endfunction

	// ---- stimulus generation ----
	function automatic void push_item(input logic [KIND_W-1:0] kind, input int sp,
			input int ot, input int rt);
		ctl_event_t e;
		e.kind = kind;
		e.sp   = TEMP_W'(sp);
		e.ot   = TEMP_W'(ot);
		e.rt   = ROOM_W'(rt);
		event_q.push_back(e);
		if (kind == KIND_MODE)
			gen_mode2 = (gen_mode2 == MODE_AUTO) ? MODE_HEAT : gen_mode2 + 1'b1;
		else if (kind == KIND_OFF)
			gen_mode2 = MODE_OFF;
	endfunction

	function automatic ctl_event_t random_event();
		ctl_event_t e;
		int r, w_tick, w_mode, w_step, w_off, w_sample, sp, ot, rt;
		r = $urandom_range(0, 99);
		case (gen_mode2)
			MODE_OFF:  begin w_tick = 15; w_mode = 65; w_step = 80; w_off = 82; w_sample = 95; end
			MODE_HEAT: begin w_tick = 40; w_mode = 46; w_step = 86; w_off = 88; w_sample = 93; end
			MODE_COOL: begin w_tick = 20; w_mode = 26; w_step = 86; w_off = 88; w_sample = 93; end
			default:   begin w_tick = 25; w_mode = 32; w_step = 48; w_off = 50; w_sample = 95; end
		endcase
		if (r < w_tick) e.kind = KIND_TICK;
		else if (r < w_mode) e.kind = KIND_MODE;
		else if (r < w_step) e.kind = ($urandom_range(0, 9) < 6) ? KIND_UP : KIND_DOWN;
		else if (r < w_off) e.kind = KIND_OFF;
		else if (r < w_sample) e.kind = KIND_SAMPLE;
		else e.kind = $urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B;

		sp = $urandom_range(0, 1000);
		case ($urandom_range(0, 2))
			0:       ot = $urandom_range(0, 1000);
			1:       ot = summer_thr + int'($urandom_range(0, 40));
			default: ot = winter_thr - int'($urandom_range(0, 40));
		endcase
		if (ot < 0) ot = 0;
		if (ot > 1000) ot = 1000;
		if ($urandom_range(0, 9) < 7) rt = sp + int'($urandom_range(0, 260)) - 130;
		else rt = $urandom_range(0, 5000);
		if (rt < 0) rt = 0;
		if (rt > 5000) rt = 5000;
		e.sp = TEMP_W'(sp);
		e.ot = TEMP_W'(ot);
		e.rt = ROOM_W'(rt);
		return e;
	endfunction

	// one word, or now and then a run of up or down presses to reach the limits
	task automatic push_random(inout int count);
		ctl_event_t e;
		logic [KIND_W-1:0] k;
		int n;
		if (gen_mode2 != MODE_OFF && $urandom_range(0, 99) < 4) begin
			k = ($urandom_range(0, 3) != 0) ? KIND_UP : KIND_DOWN;
			n = $urandom_range(5, 24);
			repeat (n) begin
				e = random_event();
				push_item(k, e.sp, e.ot, e.rt);
			end
			count += n;
		end else begin
			e = random_event();
			push_item(e.kind, e.sp, e.ot, e.rt);
			count++;
		end
	endtask

	task automatic wait_drained();
		@(posedge clk);
		#1;
		while (event_q.size() != 0 || s_tvalid || status_q.size() != 0) begin
			@(posedge clk);
			#1;
		end
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input int val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CFG_W'(val);
		case (idx)
			REG_SUMMER:   summer_thr = val & 10'h3FF;
			REG_WINTER:   winter_thr = val & 10'h3FF;
			REG_COOL_MIN: cool_min   = val & 7'h7F;
			REG_BOOST:    boost_sp   = val & 10'h3FF;
			default: ;
		endcase
	endtask

	task automatic write_settings(input int summer, input int winter, input int cmin,
			input int boost);
		write_reg(REG_SUMMER, summer);
		write_reg(REG_WINTER, winter);
		write_reg(REG_COOL_MIN, cmin);
		write_reg(REG_BOOST, boost);
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// ---- sender ----
	always @(negedge clk) begin
		if (!s_tvalid || s_took) begin
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (event_q.size() != 0) begin
				bus_ev = event_q.pop_front();
				s_tuser  <= bus_ev.kind;
				s_tdata  <= {7'b0, bus_ev.rt, bus_ev.ot, bus_ev.sp};
				s_tvalid <= 1'b1;
				send_gap = pick_gap();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// ---- receiver ----
	always @(negedge clk) begin
		if (long_hold && !hold_done) begin
			hold_left = 300;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			stall_left = pick_gap();
		end
	end

	// ---- prediction and checking ----
	always @(posedge clk) begin
		if (arst_n) begin
			s_took = s_tvalid && s_tready;
			if (s_took) begin
				if (s_tuser == KIND_SAMPLE && ctl.mode == MODE_AUTO) auto_samples++;
				if (s_tuser == KIND_TICK && ctl.timer_on) running_ticks++;
				advance_controller(s_tuser, int'(s_tdata[9:0]), int'(s_tdata[19:10]),
					int'(s_tdata[32:20]));
				status_q.push_back(controller_status());
				words_in++;
			end
			if (m_tvalid && m_tready) begin
				if (status_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t unexpected result word %h", $time, m_tdata);
				end else begin
					check_status(status_q.pop_front(), status_t'(m_tdata[25:0]));
				end
				words_out++;
			end
		end
	end

	initial begin
		#12_000_000;
		$display("timeout: %0d words in, %0d results out", words_in, words_out);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int ph, count;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: off-mode no-ops, spare kinds, each mode, lower limits, auto samples in each band
		push_item(KIND_TICK, 0, 0, 0);
		push_item(KIND_UP, 1000, 1000, 5000);
		push_item(KIND_SAMPLE, 500, 1000, 0);
		push_item(KIND_SPARE_A, 1000, 1000, 5000);
		push_item(KIND_SPARE_B, 0, 0, 0);
		push_item(KIND_MODE, 0, 0, 0);
		push_item(KIND_DOWN, 0, 0, 0);
		push_item(KIND_UP, 0, 0, 0);
		push_item(KIND_UP, 0, 0, 0);
		push_item(KIND_TICK, 0, 0, 0);
		push_item(KIND_TICK, 0, 0, 0);
		push_item(KIND_MODE, 0, 0, 0);
		push_item(KIND_UP, 0, 0, 0);
		push_item(KIND_DOWN, 0, 0, 0);
		push_item(KIND_DOWN, 0, 0, 0);
		push_item(KIND_MODE, 0, 0, 0);
		push_item(KIND_UP, 0, 0, 0);
		push_item(KIND_UP, 0, 0, 0);
		push_item(KIND_SAMPLE, 0, 1000, 5000);
		push_item(KIND_SAMPLE, 500, 700, 505);
		push_item(KIND_SAMPLE, 1000, 1000, 0);
		push_item(KIND_SAMPLE, 1000, 0, 0);
		push_item(KIND_SAMPLE, 300, 0, 290);
		push_item(KIND_SAMPLE, 600, 100, 530);
		push_item(KIND_SAMPLE, 200, 0, 300);
		push_item(KIND_SAMPLE, 500, 500, 500);
		push_item(KIND_TICK, 0, 0, 0);
		push_item(KIND_OFF, 0, 0, 0);
		wait_drained();

		for (ph = 0; ph < 5; ph++) begin
			case (ph)
				0: write_settings(SUMMER_RST, WINTER_RST, COOL_MIN_RST, BOOST_RST);
				1: write_settings(0, 0, 0, 0);
				2: write_settings(1000, 1000, 100, 1000);
				default: write_settings($urandom_range(0, 1000), $urandom_range(0, 1000),
					$urandom_range(0, 100), $urandom_range(0, 1000));
			endcase
			steady = (ph == 3);
			count = 0;
			while (count < 135) push_random(count);
			if (ph == 1) long_hold = 1'b1;
			if (ph == 4) wait_drained();
			while (count < 270) push_random(count);
			wait_drained();
		end

		repeat (10) @(posedge clk);
		$display("covered %0d words over %0d register settings:", words_in, settings_used);
		$display("  %0d auto samples, %0d PWM ticks", auto_samples, running_ticks);
		$display("checked %0d result words, %0d failures", words_out, fail_count);
		if (fail_count == 0 && status_q.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/hcmc_pkg.sv
rtl/heat_cool_mode_controller.sv
sim/tb.sv
